>>> sv/tamr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package tamr_pkg;

    localparam int DATA_W     = 16;
    localparam int SIZE_W     = 13;
    localparam int POS_W      = 12;
    localparam int IDX_W      = 12;
    localparam int AXES       = 4;
    localparam int DIM_MAX    = 4096;
    localparam int ACC_DEPTH  = 4096;
    localparam int ADDR_W     = $clog2(ACC_DEPTH);
    localparam int CFG_IDX_W  = 3;
    localparam int OUTQ_DEPTH = 4;
    localparam int OUTQ_PTR_W = $clog2(OUTQ_DEPTH);

    localparam logic [CFG_IDX_W-1:0] REG_MODE     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BATCHES  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CHANNELS = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ROWS     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_COLS     = 3'd4;

    localparam logic [2:0] MODE_ALL = 3'd0;
    localparam logic [2:0] MODE_N   = 3'd1;
    localparam logic [2:0] MODE_C   = 3'd2;
    localparam logic [2:0] MODE_H   = 3'd3;
    localparam logic [2:0] MODE_W   = 3'd4;
    localparam logic [2:0] MODE_NC  = 3'd5;
    localparam logic [2:0] MODE_CH  = 3'd6;
    localparam logic [2:0] MODE_HW  = 3'd7;

    // axis order: 0 N, 1 C, 2 H, 3 W
    typedef struct packed {
        logic [AXES-1:0]             red;
        logic [AXES-1:0][POS_W-1:0]  lim;
        logic [AXES-1:0][ADDR_W-1:0] stride;
        logic                        err;
        logic                        busy;
    } t_geom;

    typedef struct packed {
        logic [ADDR_W-1:0] addr;
        logic              first;
        logic              last;
        logic              tend;
        logic [IDX_W-1:0]  idx;
        logic              err;
    } t_item;

    typedef struct packed {
        logic signed [DATA_W-1:0] min_value;
        logic [IDX_W-1:0]         out_index;
        logic                     last_result;
        logic                     config_error;
    } t_result;

    function automatic logic [AXES-1:0] red_mask(input logic [2:0] mode);
        logic [AXES-1:0] m;
        unique case (mode)
            MODE_ALL: m = 4'b1111;
            MODE_N:   m = 4'b0001;
            MODE_C:   m = 4'b0010;
            MODE_H:   m = 4'b0100;
            MODE_W:   m = 4'b1000;
            MODE_NC:  m = 4'b0011;
            MODE_CH:  m = 4'b0110;
            MODE_HW:  m = 4'b1100;
            default:  m = 4'b1111;
        endcase
        return m;
    endfunction

endpackage

`default_nettype wire

>>> sv/tamr_cfg.sv
`timescale 1ns / 1ps
`default_nettype none

module tamr_cfg (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_cfg_valid,
    input  wire logic [tamr_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  wire logic [tamr_pkg::SIZE_W-1:0]        i_cfg_data,
    output logic                                    o_restart,
    output tamr_pkg::t_geom                         o_geom
);

    localparam int PROD_W = 2 * tamr_pkg::SIZE_W;
    localparam int PW_W   = 2 * tamr_pkg::ADDR_W;

    logic [2:0]                                     r_mode;
    logic [tamr_pkg::AXES-1:0][tamr_pkg::SIZE_W-1:0] r_size;
    logic [1:0]                                     r_busy;

    logic [tamr_pkg::AXES-1:0]                      w_red;
    logic [tamr_pkg::AXES-1:0][tamr_pkg::POS_W-1:0]  w_lim;
    logic [tamr_pkg::AXES-1:0][tamr_pkg::SIZE_W-1:0] w_ks;
    logic                                           w_hit;
    logic [PW_W-1:0]                                w_str_n_full;

    logic [PROD_W-1:0]                              r_p_wh;
    logic [PROD_W-1:0]                              r_p_whc;
    logic [tamr_pkg::ADDR_W-1:0]                    r_str_w;
    logic [tamr_pkg::ADDR_W-1:0]                    r_str_h;
    logic [tamr_pkg::ADDR_W-1:0]                    r_str_c;
    logic [tamr_pkg::ADDR_W-1:0]                    r_str_n;
    logic                                           r_err;

    function automatic logic [tamr_pkg::POS_W-1:0] eff_lim(
        input logic [tamr_pkg::SIZE_W-1:0] v
    );
        logic [tamr_pkg::POS_W-1:0] l;
        if (v == '0) begin
            l = '0;
        end else if (v > tamr_pkg::SIZE_W'(tamr_pkg::DIM_MAX)) begin
            l = tamr_pkg::POS_W'(tamr_pkg::DIM_MAX - 1);
        end else begin
            l = tamr_pkg::POS_W'(v - 1'b1);
        end
        return l;
    endfunction

    function automatic logic [tamr_pkg::SIZE_W-1:0] sat_size(input logic [PROD_W-1:0] p);
        logic [tamr_pkg::SIZE_W-1:0] s;
        if (p > PROD_W'(tamr_pkg::ACC_DEPTH)) begin
            s = tamr_pkg::SIZE_W'(tamr_pkg::ACC_DEPTH + 1);
        end else begin
            s = p[tamr_pkg::SIZE_W-1:0];
        end
        return s;
    endfunction

    always_comb begin
        w_hit = 1'b0;
        if (i_cfg_valid) begin
            unique case (i_cfg_index)
                tamr_pkg::REG_MODE,
                tamr_pkg::REG_BATCHES,
                tamr_pkg::REG_CHANNELS,
                tamr_pkg::REG_ROWS,
                tamr_pkg::REG_COLS: w_hit = 1'b1;
                default:            w_hit = 1'b0;
            endcase
        end
    end

    always_comb begin
        w_red = tamr_pkg::red_mask(r_mode);
        for (int i = 0; i < tamr_pkg::AXES; i++) begin
            w_lim[i] = eff_lim(r_size[i]);
            w_ks[i]  = w_red[i] ? tamr_pkg::SIZE_W'(1)
                                : tamr_pkg::SIZE_W'({1'b0, w_lim[i]}) + 1'b1;
        end
        w_str_n_full = r_p_wh[tamr_pkg::ADDR_W-1:0] * w_ks[1][tamr_pkg::ADDR_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= tamr_pkg::MODE_ALL;
            for (int i = 0; i < tamr_pkg::AXES; i++) begin
                r_size[i] <= tamr_pkg::SIZE_W'(1);
            end
            r_busy <= 2'd3;
        end else begin
            if (w_hit) begin
                unique case (i_cfg_index)
                    tamr_pkg::REG_MODE:     r_mode    <= i_cfg_data[2:0];
                    tamr_pkg::REG_BATCHES:  r_size[0] <= i_cfg_data;
                    tamr_pkg::REG_CHANNELS: r_size[1] <= i_cfg_data;
                    tamr_pkg::REG_ROWS:     r_size[2] <= i_cfg_data;
                    tamr_pkg::REG_COLS:     r_size[3] <= i_cfg_data;
                    default:                r_mode    <= r_mode;
                endcase
                r_busy <= 2'd3;
            end else if (r_busy != 2'd0) begin
                r_busy <= r_busy - 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_p_wh  <= PROD_W'(w_ks[3]) * PROD_W'(w_ks[2]);
        r_str_w <= w_red[3] ? '0 : tamr_pkg::ADDR_W'(1);
        r_str_h <= w_red[2] ? '0 : w_ks[3][tamr_pkg::ADDR_W-1:0];
        r_str_c <= w_red[1] ? '0 : r_p_wh[tamr_pkg::ADDR_W-1:0];
        r_p_whc <= PROD_W'(sat_size(r_p_wh)) * PROD_W'(w_ks[1]);
        r_str_n <= w_red[0] ? '0 : w_str_n_full[tamr_pkg::ADDR_W-1:0];
        r_err   <= (PROD_W'(sat_size(r_p_whc)) * PROD_W'(w_ks[0]))
                   > PROD_W'(tamr_pkg::ACC_DEPTH);
    end

    assign o_restart        = w_hit;
    assign o_geom.red       = w_red;
    assign o_geom.lim       = w_lim;
    assign o_geom.stride[0] = r_str_n;
    assign o_geom.stride[1] = r_str_c;
    assign o_geom.stride[2] = r_str_h;
    assign o_geom.stride[3] = r_str_w;
    assign o_geom.err       = r_err;
    assign o_geom.busy      = (r_busy != 2'd0);

endmodule

`default_nettype wire

>>> sv/tamr_pos.sv
`timescale 1ns / 1ps
`default_nettype none

module tamr_pos (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_accept,
    input  wire logic            i_restart,
    input  wire tamr_pkg::t_geom i_geom,
    output tamr_pkg::t_item      o_item
);

    logic [tamr_pkg::AXES-1:0][tamr_pkg::POS_W-1:0]  r_pos;
    logic [tamr_pkg::AXES-1:0][tamr_pkg::ADDR_W-1:0] r_off;
    logic [tamr_pkg::IDX_W-1:0]                     r_emit;

    logic [tamr_pkg::AXES-1:0][tamr_pkg::POS_W-1:0]  n_pos;
    logic [tamr_pkg::AXES-1:0][tamr_pkg::ADDR_W-1:0] n_off;
    logic [tamr_pkg::IDX_W-1:0]                     n_emit;
    logic [tamr_pkg::AXES-1:0]                      w_at_end;
    logic [tamr_pkg::AXES-1:0]                      w_zero;

    always_comb begin
        logic carry;
        carry = 1'b1;
        for (int i = 0; i < tamr_pkg::AXES; i++) begin
            w_at_end[i] = (r_pos[i] == i_geom.lim[i]);
            w_zero[i]   = (r_pos[i] == '0);
        end
        o_item.first = &(~i_geom.red | w_zero);
        o_item.last  = &(~i_geom.red | w_at_end);
        o_item.tend  = &w_at_end;
        o_item.addr  = r_off[0] + r_off[1] + r_off[2] + r_off[3];
        o_item.idx   = r_emit;
        o_item.err   = i_geom.err;
        n_pos = r_pos;
        n_off = r_off;
        for (int i = tamr_pkg::AXES - 1; i >= 0; i--) begin
            if (carry) begin
                if (w_at_end[i]) begin
                    n_pos[i] = '0;
                    n_off[i] = '0;
                end else begin
                    n_pos[i] = r_pos[i] + 1'b1;
                    n_off[i] = r_off[i] + i_geom.stride[i];
                    carry    = 1'b0;
                end
            end
        end
        if (o_item.tend) begin
            n_emit = '0;
        end else if (o_item.last) begin
            n_emit = r_emit + 1'b1;
        end else begin
            n_emit = r_emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_restart) begin
            for (int i = 0; i < tamr_pkg::AXES; i++) begin
                r_pos[i] <= '0;
                r_off[i] <= '0;
            end
            r_emit <= '0;
        end else if (i_accept) begin
            r_pos  <= n_pos;
            r_off  <= n_off;
            r_emit <= n_emit;
        end
    end

endmodule

`default_nettype wire

>>> sv/tamr_acc.sv
`timescale 1ns / 1ps
`default_nettype none

module tamr_acc (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire logic                                 i_accept,
    input  wire tamr_pkg::t_item                      i_item,
    input  wire logic signed [tamr_pkg::DATA_W-1:0]   i_sample,
    output logic                                      o_push,
    output tamr_pkg::t_result                         o_res
);

    logic signed [tamr_pkg::DATA_W-1:0] r_mem [tamr_pkg::ACC_DEPTH];
    logic signed [tamr_pkg::DATA_W-1:0] r_q;

    logic                               r_b_valid;
    tamr_pkg::t_item                    r_b;
    logic signed [tamr_pkg::DATA_W-1:0] r_b_sample;
    logic                               r_fwd_hit;
    logic signed [tamr_pkg::DATA_W-1:0] r_fwd_val;

    logic signed [tamr_pkg::DATA_W-1:0] w_old;
    logic signed [tamr_pkg::DATA_W-1:0] w_new;

    always_comb begin
        w_old = r_fwd_hit ? r_fwd_val : r_q;
        w_new = (r_b.first || (r_b_sample < w_old)) ? r_b_sample : w_old;
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_q <= r_mem[i_item.addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_b_valid) begin
            r_mem[r_b.addr] <= w_new;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
            r_fwd_hit <= 1'b0;
        end else begin
            r_b_valid <= i_accept;
            r_fwd_hit <= i_accept && r_b_valid && (i_item.addr == r_b.addr);
        end
    end

    always_ff @(posedge i_clk) begin
        r_fwd_val <= w_new;
        if (i_accept) begin
            r_b        <= i_item;
            r_b_sample <= i_sample;
        end
    end

    assign o_push             = r_b_valid && r_b.last;
    assign o_res.min_value    = w_new;
    assign o_res.out_index    = r_b.idx;
    assign o_res.last_result  = r_b.tend;
    assign o_res.config_error = r_b.err;

endmodule

`default_nettype wire

>>> sv/tamr_outq.sv
`timescale 1ns / 1ps
`default_nettype none

module tamr_outq (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_push,
    input  wire tamr_pkg::t_result             i_res,
    input  wire logic                          i_stall,
    output logic                               o_valid,
    output tamr_pkg::t_result                  o_res,
    output logic [tamr_pkg::OUTQ_PTR_W:0]      o_count
);

    tamr_pkg::t_result                r_mem [tamr_pkg::OUTQ_DEPTH];
    logic [tamr_pkg::OUTQ_PTR_W-1:0]  r_wr;
    logic [tamr_pkg::OUTQ_PTR_W-1:0]  r_rd;
    logic [tamr_pkg::OUTQ_PTR_W:0]    r_cnt;
    logic                             w_pop;

    assign o_valid = (r_cnt != '0);
    assign w_pop   = o_valid && !i_stall;
    assign o_res   = r_mem[r_rd];
    assign o_count = r_cnt;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (w_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            case ({i_push, w_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

`default_nettype wire

>>> sv/tensor_axis_min_reduce_top.sv
`timescale 1ns / 1ps
`default_nettype none

// Streaming minimum over chosen axes of an N,C,H,W tensor. One element is
// taken per cycle: the partial-minimum memory does one read and one write
// per cycle, and an element that hits the entry written just before it gets
// the new value forwarded. The input stalls after reset and after each
// mapped configuration write, while the stride and size-check multiplier
// pipeline settles, and whenever the 4-beat result queue could overflow.
// A result is pushed from the accumulator stage holding the element that ends
// its group. A mapped configuration write restarts the tensor; config_error
// is set on every result while the product of kept axis sizes exceeds 4096.
module tensor_axis_min_reduce_top (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_valid,
    output logic                                     o_stall,
    input  wire logic signed [tamr_pkg::DATA_W-1:0]  i_sample,
    output logic                                     o_valid,
    input  wire logic                                i_stall,
    output logic signed [tamr_pkg::DATA_W-1:0]      o_min_value,
    output logic [tamr_pkg::IDX_W-1:0]               o_out_index,
    output logic                                     o_last_result,
    output logic                                     o_config_error,
    input  wire logic                                i_cfg_valid,
    output logic                                     o_cfg_ready,
    input  wire logic [tamr_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  wire logic [tamr_pkg::SIZE_W-1:0]         i_cfg_data
);

    tamr_pkg::t_geom                 w_geom;
    tamr_pkg::t_item                 w_item;
    tamr_pkg::t_result               w_res;
    tamr_pkg::t_result               w_head;
    logic                            w_restart;
    logic                            w_accept;
    logic                            w_push;
    logic [tamr_pkg::OUTQ_PTR_W:0]   w_count;

    assign o_cfg_ready = 1'b1;
    assign o_stall     = w_geom.busy ||
                         ((w_count + (tamr_pkg::OUTQ_PTR_W + 1)'(w_push))
                          >= (tamr_pkg::OUTQ_PTR_W + 1)'(tamr_pkg::OUTQ_DEPTH));
    assign w_accept    = i_valid && !o_stall;

    tamr_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_restart   (w_restart),
        .o_geom      (w_geom)
    );

    tamr_pos u_pos (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_accept  (w_accept),
        .i_restart (w_restart),
        .i_geom    (w_geom),
        .o_item    (w_item)
    );

    tamr_acc u_acc (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (w_accept),
        .i_item   (w_item),
        .i_sample (i_sample),
        .o_push   (w_push),
        .o_res    (w_res)
    );

    tamr_outq u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_res   (w_res),
        .i_stall (i_stall),
        .o_valid (o_valid),
        .o_res   (w_head),
        .o_count (w_count)
    );

    assign o_min_value    = w_head.min_value;
    assign o_out_index    = w_head.out_index;
    assign o_last_result  = w_head.last_result;
    assign o_config_error = w_head.config_error;

endmodule

`default_nettype wire

>>> tb/min_reduce_monitor.sv
`timescale 1ns / 1ps

module min_reduce_monitor (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_smp_valid,
    input  wire logic                                i_smp_stall,
    input  wire logic signed [tamr_pkg::DATA_W-1:0]  i_sample,
    input  wire logic                                i_res_valid,
    input  wire logic                                i_res_stall,
    input  wire logic signed [tamr_pkg::DATA_W-1:0]  i_min_value,
    input  wire logic [tamr_pkg::IDX_W-1:0]          i_out_index,
    input  wire logic                                i_last_result,
    input  wire logic                                i_config_error,
    input  wire logic                                i_cfg_valid,
    input  wire logic                                i_cfg_ready,
    input  wire logic [tamr_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  wire logic [tamr_pkg::SIZE_W-1:0]         i_cfg_data,
    output int                                       o_mismatches,
    output int                                       o_outstanding
);

    import tamr_pkg::*;

    logic signed [DATA_W-1:0] partial_min [ACC_DEPTH];
    logic [SIZE_W-1:0]        dim [AXES];
    logic [2:0]               mode;
    int                       pos [AXES];
    logic [IDX_W-1:0]         emitted;
    t_result                  expected_minima [$];
    int                       mismatches = 0;

    initial begin
        o_mismatches  = 0;
        o_outstanding = 0;
    end

    // bit a set means axis a (0 N, 1 C, 2 H, 3 W) is folded into the minimum
    function automatic logic [AXES-1:0] folded_axes(input logic [2:0] m);
        case (m)
            MODE_ALL: return 4'b1111;
            MODE_N:   return 4'b0001;
            MODE_C:   return 4'b0010;
            MODE_H:   return 4'b0100;
            MODE_W:   return 4'b1000;
            MODE_NC:  return 4'b0011;
            MODE_CH:  return 4'b0110;
            default:  return 4'b1100;
        endcase
    endfunction

    function automatic int clamp_dim(input logic [SIZE_W-1:0] d);
        if (d == 0) return 1;
        if (d > DIM_MAX) return DIM_MAX;
        return int'(d);
    endfunction

    task automatic restart_tensor();
        foreach (pos[a]) pos[a] = 0;
        emitted = '0;
    endtask

    task automatic report(input string msg);
        mismatches++;
        if (mismatches <= 10) $display("%0t: %s", $realtime, msg);
    endtask

    task automatic fold_sample(input logic signed [DATA_W-1:0] x);
        logic [AXES-1:0] folded;
        int              sz [AXES];
        longint          kept_idx;
        longint          kept_size;
        bit              opens;
        bit              closes;
        bit              wraps;
        int              addr;
        t_result         res;
        folded    = folded_axes(mode);
        kept_idx  = 0;
        kept_size = 1;
        opens     = 1'b1;
        closes    = 1'b1;
        wraps     = 1'b1;
        for (int a = 0; a < AXES; a++) begin
            sz[a] = clamp_dim(dim[a]);
            if (pos[a] < sz[a] - 1) wraps = 1'b0;
            if (folded[a]) begin
                if (pos[a] != 0) opens = 1'b0;
                if (pos[a] < sz[a] - 1) closes = 1'b0;
            end else begin
                kept_idx  = kept_idx * sz[a] + ((pos[a] < sz[a]) ? pos[a] : sz[a] - 1);
                kept_size = kept_size * sz[a];
            end
        end
        addr = int'(kept_idx % ACC_DEPTH);
        if (opens || x < partial_min[addr]) partial_min[addr] = x;
        if (closes) begin
            res.min_value    = partial_min[addr];
            res.out_index    = emitted;
            res.last_result  = wraps;
            res.config_error = kept_size > ACC_DEPTH;
            expected_minima.push_back(res);
            emitted = emitted + 1'b1;
        end
        if (wraps) begin
            restart_tensor();
        end else begin
            for (int a = AXES - 1; a >= 0; a--) begin
                if (pos[a] < sz[a] - 1) begin
                    pos[a]++;
                    break;
                end
                pos[a] = 0;
            end
        end
    endtask

    always @(posedge i_clk) begin : watch
        t_result got;
        t_result want;
        bit      known;
        if (!i_rst_n) begin
            mode = MODE_ALL;
            foreach (dim[a]) dim[a] = 1;
            restart_tensor();
            expected_minima.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                known = 1'b1;
                case (i_cfg_index)
                    REG_MODE:     mode   = i_cfg_data[2:0];
                    REG_BATCHES:  dim[0] = i_cfg_data;
                    REG_CHANNELS: dim[1] = i_cfg_data;
                    REG_ROWS:     dim[2] = i_cfg_data;
                    REG_COLS:     dim[3] = i_cfg_data;
                    default:      known  = 1'b0;
                endcase
                if (known) restart_tensor();
            end
            if (i_smp_valid && !i_smp_stall) fold_sample(i_sample);
            if (i_res_valid && !i_res_stall) begin
                got.min_value    = i_min_value;
                got.out_index    = i_out_index;
                got.last_result  = i_last_result;
                got.config_error = i_config_error;
                if (expected_minima.size() == 0) begin
                    report($sformatf("unexpected beat: min %0d index %0d last %0b err %0b",
                        got.min_value, got.out_index, got.last_result, got.config_error));
                end else begin
                    want = expected_minima.pop_front();
                    if (got.min_value !== want.min_value || got.out_index !== want.out_index
                        || got.last_result !== want.last_result
                        || got.config_error !== want.config_error) begin
                        report($sformatf({"mismatch: expected min %0d index %0d last %0b ",
                            "err %0b, got min %0d index %0d last %0b err %0b"},
                            want.min_value, want.out_index, want.last_result,
                            want.config_error, got.min_value, got.out_index,
                            got.last_result, got.config_error));
                    end
                end
            end
        end
        o_mismatches  <= mismatches;
        o_outstanding <= expected_minima.size();
    end

endmodule

>>> tb/tensor_axis_min_reduce_top_tb.sv
`timescale 1ns / 1ps

module tensor_axis_min_reduce_top_tb;

    import tamr_pkg::*;

    localparam int CYCLE_LIMIT  = 1000000;
    localparam int DRAIN_CYCLES = 12;
    localparam int HOLD_CYCLES  = 400;
    localparam int RANDOM_ITEMS = 750;
    localparam int PRESS_ITEMS  = 120;

    localparam logic [CFG_IDX_W-1:0] REG_TOP_INDEX = '1;
    localparam logic [SIZE_W-1:0]    DIM_FULL      = '1;

    logic                     i_clk = 1'b0;
    logic                     i_rst_n;
    logic                     i_valid;
    logic                     o_stall;
    logic signed [DATA_W-1:0] i_sample;
    logic                     o_valid;
    logic                     i_stall;
    logic signed [DATA_W-1:0] o_min_value;
    logic [IDX_W-1:0]         o_out_index;
    logic                     o_last_result;
    logic                     o_config_error;
    logic                     i_cfg_valid;
    logic                     o_cfg_ready;
    logic [CFG_IDX_W-1:0]     i_cfg_index;
    logic [SIZE_W-1:0]        i_cfg_data;

    int                mismatches;
    int                outstanding;
    int                cycles = 0;
    bit                hold_req = 1'b0;
    logic [SIZE_W-1:0] shape [AXES] = '{default: 1};

    tensor_axis_min_reduce_top uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_sample       (i_sample),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_min_value    (o_min_value),
        .o_out_index    (o_out_index),
        .o_last_result  (o_last_result),
        .o_config_error (o_config_error),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    min_reduce_monitor u_monitor (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_smp_valid    (i_valid),
        .i_smp_stall    (o_stall),
        .i_sample       (i_sample),
        .i_res_valid    (o_valid),
        .i_res_stall    (i_stall),
        .i_min_value    (o_min_value),
        .i_out_index    (o_out_index),
        .i_last_result  (o_last_result),
        .i_config_error (o_config_error),
        .i_cfg_valid    (i_cfg_valid),
        .i_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .o_mismatches   (mismatches),
        .o_outstanding  (outstanding)
    );

    always #1 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("tensor_axis_min_reduce_top_tb failed");
            $finish;
        end
    end

    function automatic logic signed [DATA_W-1:0] rand_sample();
        int pick;
        pick = $urandom_range(0, 9);
        if (pick == 0) return {1'b1, {(DATA_W-1){1'b0}}};
        if (pick == 1) return {1'b0, {(DATA_W-1){1'b1}}};
        if (pick == 2) return DATA_W'(int'($urandom_range(0, 8)) - 4);
        return DATA_W'($urandom);
    endfunction

    // leaves valid high after the accepting edge
    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [SIZE_W-1:0] d);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= d;
        if (idx >= REG_BATCHES && idx <= REG_COLS) shape[idx - REG_BATCHES] = d;
        do @(posedge i_clk); while (!o_cfg_ready);
    endtask

    task automatic set_shape(input logic [2:0] m, input logic [SIZE_W-1:0] b,
                             input logic [SIZE_W-1:0] c, input logic [SIZE_W-1:0] h,
                             input logic [SIZE_W-1:0] w);
        cfg_write(REG_MODE, SIZE_W'(m));
        cfg_write(REG_BATCHES, b);
        cfg_write(REG_CHANNELS, c);
        cfg_write(REG_ROWS, h);
        cfg_write(REG_COLS, w);
        i_cfg_valid <= 1'b0;
    endtask

    // leaves valid high after the accepting edge
    task automatic push_sample(input logic signed [DATA_W-1:0] v, input bit gappy);
        int gap;
        int pick;
        pick = $urandom_range(0, 99);
        if (!gappy || pick < 65) gap = 0;
        else if (pick < 90) gap = $urandom_range(1, 3);
        else if (pick < 97) gap = $urandom_range(4, 12);
        else gap = $urandom_range(20, 60);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid  <= 1'b1;
        i_sample <= v;
        do @(posedge i_clk); while (o_stall);
    endtask

    task automatic settle();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (outstanding != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    initial begin : backpressure
        int left;
        bit level;
        bit hold_done;
        int pick;
        left      = 0;
        level     = 1'b0;
        hold_done = 1'b0;
        i_stall <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_req && !hold_done) begin
                level     = 1'b1;
                left      = HOLD_CYCLES;
                hold_done = 1'b1;
            end else if (left <= 0) begin
                pick = $urandom_range(0, 99);
                if (pick < 50) begin
                    level = 1'b0;
                    left  = $urandom_range(1, 8);
                end else if (pick < 60) begin
                    level = 1'b0;
                    left  = $urandom_range(50, 200);
                end else if (pick < 92) begin
                    level = 1'b1;
                    left  = $urandom_range(1, 3);
                end else begin
                    level = 1'b1;
                    left  = $urandom_range(20, 60);
                end
            end
            i_stall <= level;
            left--;
        end
    end

    initial begin : stimulus
        int                sent;
        int                n;
        int                pick;
        longint            len;
        bit                gappy;
        logic [SIZE_W-1:0] d;
        i_rst_n     <= 1'b0;
        i_valid     <= 1'b0;
        i_sample    <= '0;
        i_cfg_valid <= 1'b0;
        i_cfg_index <= REG_MODE;
        i_cfg_data  <= '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset shape: every beat is a whole tensor
        push_sample(16'h8000, 1'b0);
        push_sample(16'h7fff, 1'b0);
        push_sample(16'h0000, 1'b0);
        push_sample(16'hffff, 1'b0);
        settle();

        // wrap into a second tensor, then an unmapped write that must not restart it
        set_shape(MODE_ALL, 1, 1, 1, 3);
        push_sample(16'sd5, 1'b0);
        push_sample(-16'sd3, 1'b0);
        push_sample(16'sd7, 1'b0);
        push_sample(16'sd100, 1'b0);
        settle();
        cfg_write(REG_TOP_INDEX, DIM_FULL);
        i_cfg_valid <= 1'b0;
        push_sample(16'sd200, 1'b1);
        push_sample(16'sd50, 1'b1);
        settle();

        // zero and oversized sizes clamp; kept size overflows the accumulator
        set_shape(MODE_H, 1, 2, 0, DIM_FULL);
        repeat (6) push_sample(rand_sample(), 1'b1);
        settle();

        set_shape(MODE_C, 1, 2, 1, 2);
        push_sample(16'sd9, 1'b0);
        push_sample(-16'sd9, 1'b0);
        push_sample(16'sd4, 1'b0);
        push_sample(-16'sd20, 1'b0);
        settle();

        // one beat per sample while the receiver holds off
        set_shape(MODE_W, SIZE_W'($urandom_range(1, 3)), SIZE_W'($urandom_range(1, 3)),
                  SIZE_W'($urandom_range(1, 3)), 1);
        hold_req <= 1'b1;
        repeat (PRESS_ITEMS) push_sample(rand_sample(), 1'b0);
        settle();
        sent = PRESS_ITEMS;

        while (sent < RANDOM_ITEMS) begin
            gappy = $urandom_range(0, 3) != 0;
            for (int r = REG_MODE; r <= REG_COLS; r++) begin
                if ($urandom_range(0, 3) != 0) begin
                    pick = $urandom_range(0, 19);
                    if (r == REG_MODE) d = SIZE_W'($urandom);
                    else if (pick == 0) d = '0;
                    else if (pick == 1) d = SIZE_W'(DIM_MAX);
                    else if (pick == 2) d = DIM_FULL;
                    else if (pick == 3) d = SIZE_W'($urandom_range(5, 8));
                    else d = SIZE_W'($urandom_range(1, 4));
                    cfg_write(CFG_IDX_W'(r), d);
                end
            end
            if ($urandom_range(0, 7) == 0)
                cfg_write(CFG_IDX_W'($urandom_range(REG_COLS + 1, REG_TOP_INDEX)),
                          SIZE_W'($urandom));
            i_cfg_valid <= 1'b0;
            len = 1;
            foreach (shape[a])
                len *= (shape[a] == 0) ? 1 : ((shape[a] > DIM_MAX) ? DIM_MAX : shape[a]);
            if (len <= 64) begin
                n = int'(len) * $urandom_range(1, 3);
                if ($urandom_range(0, 3) == 0) n += $urandom_range(1, int'(len));
            end else begin
                n = $urandom_range(20, 80);
            end
            repeat (n) push_sample(rand_sample(), gappy);
            sent += n;
            settle();
        end

        if (mismatches == 0 && outstanding == 0)
            $display("tensor_axis_min_reduce_top_tb passed");
        else
            $display("tensor_axis_min_reduce_top_tb failed");
        $finish;
    end

endmodule

>>> sim.f
sv/tamr_pkg.sv
sv/tamr_cfg.sv
sv/tamr_pos.sv
sv/tamr_acc.sv
sv/tamr_outq.sv
sv/tensor_axis_min_reduce_top.sv
tb/min_reduce_monitor.sv
tb/tensor_axis_min_reduce_top_tb.sv
